// ----- src/idef_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idef_pkg
// Shared types, register indexes and mode codes of the edge filter.
// ----------------------------------------------------------------------------
package idef_pkg;

  localparam int CFG_W = 13;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [IDX_W-1:0] REG_COLOUR     = 3'd1;
  localparam logic [IDX_W-1:0] REG_LINE_BYTES = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROWS       = 3'd3;

  localparam logic [2:0] MODE_VERT  = 3'd0;
  localparam logic [2:0] MODE_HORIZ = 3'd1;
  localparam logic [2:0] MODE_MAG   = 3'd2;
  localparam logic [2:0] MODE_CROSS = 3'd3;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_DRAIN = 1'b1;

  localparam logic [7:0] SAT_MAX = 8'd255;

  typedef struct packed {
    logic       action;
    logic [7:0] pixel;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] edge_res;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] value;
  } cfg_beat_t;

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ----- src/idef_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idef_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface idef_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/idef_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idef_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module idef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/idef_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idef_sqrt
// Bit-serial integer square root, one result bit per cycle, saturated at 255.
// ----------------------------------------------------------------------------
module idef_sqrt import idef_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] val,
  output logic        done,
  output logic [7:0]  root
);

  logic        run_r;
  logic        done_r;
  logic        big_r;
  logic [15:0] v_r;
  logic [7:0]  r_r;
  logic [2:0]  idx_r;
  logic [7:0]  trial;
  logic [15:0] sq;

  assign trial = r_r | (8'd1 << idx_r);
  assign sq    = 16'(trial) * 16'(trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        v_r   <= val[15:0];
        big_r <= val[16];
        r_r   <= '0;
        idx_r <= 3'd7;
      end else if (run_r) begin
        if (sq <= v_r) begin
          r_r <= trial;
        end
        if (idx_r == 3'd0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          idx_r <= idx_r - 3'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = big_r ? SAT_MAX : r_r;

endmodule

// ----- src/image_derivative_edge_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_derivative_edge_filter
// Streaming 3x3 derivative / Laplacian edge filter over 8-bit image bytes.
// ----------------------------------------------------------------------------
// One item is handled at a time. A drain beat is handled in the idle state. An image
// byte in modes 0, 1 and 3 to 7 goes through the registered read of the two
// line stores, then compute and write-back in S_CALC. In mode 2 a byte off the
// border then waits in S_SQRT for the bit-serial square root (8 steps plus hand-off).
// The line stores need no clearing pass; every register write to indexes 0 to 3
// restarts the frame.
module image_derivative_edge_filter import idef_pkg::*; #(
  parameter int MAX_LINE_BYTES = 4096,
  parameter int MAX_ROWS       = 4096
) (
  input  logic           clk,
  input  logic           rst_n,
  idef_chan_if.sink      in_ch,
  idef_chan_if.source    out_ch,
  idef_chan_if.sink      cfg_ch
);

  localparam int AW = $clog2(MAX_LINE_BYTES);
  localparam int LW = $clog2(MAX_LINE_BYTES + 1) + 1;
  localparam int RW = $clog2(MAX_ROWS + 1) + 1;
  localparam int PW = $clog2(MAX_LINE_BYTES * MAX_ROWS + 1) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_SQRT = 3'b100
  } state_t;

  state_t          state_r;
  logic [2:0]      mode_r;
  logic            colour_r;
  logic [CFG_W-1:0] lb_r;
  logic [CFG_W-1:0] rows_r;
  logic [AW-1:0]   col_r;
  logic [RW-1:0]   row_r;
  logic [PW-1:0]   ipos_r;
  logic [AW-1:0]   ocol_r;
  logic [RW-1:0]   orow_r;
  logic [PW-1:0]   opos_r;
  logic [7:0]      win_r [3][7];
  logic [7:0]      pix_r;
  logic            mag_last_r;
  logic            out_valid_r;
  out_beat_t       out_data_r;

  logic [LW-1:0]   eff_l;
  logic [RW-1:0]   eff_r;
  logic [LW-1:0]   stride;
  logic [LW-1:0]   lag;
  logic [LW-1:0]   col_inc;
  logic            col_wrap;
  logic [LW-1:0]   ocol_inc;
  logic            ocol_wrap;
  logic [7:0]      up;
  logic [7:0]      lo;
  logic [7:0]      dx;
  logic [7:0]      dy;
  logic            in_last;
  logic            out_last;
  logic            vert_ok;
  logic            horiz_ok;
  logic            emit3;
  logic            kern_ok;
  logic [7:0]      t0, t1, m0, m1, b0, b1;
  logic signed [11:0] ksum;
  logic [11:0]     kmag;
  logic [7:0]      kres;
  logic            in_acc;
  logic            cfg_acc;
  logic            sq_start;
  logic [16:0]     sq_val;
  logic            sq_done;
  logic [7:0]      sq_root;

  always_comb begin
    if (lb_r == '0) begin
      eff_l = LW'(1);
    end else if (32'(lb_r) > MAX_LINE_BYTES) begin
      eff_l = LW'(MAX_LINE_BYTES);
    end else begin
      eff_l = LW'(lb_r);
    end
    if (rows_r == '0) begin
      eff_r = RW'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      eff_r = RW'(MAX_ROWS);
    end else begin
      eff_r = RW'(rows_r);
    end
  end

  assign stride    = colour_r ? LW'(3) : LW'(1);
  assign lag       = eff_l + stride;
  assign col_inc   = LW'(col_r) + LW'(1);
  assign col_wrap  = col_inc >= eff_l;
  assign ocol_inc  = LW'(ocol_r) + LW'(1);
  assign ocol_wrap = ocol_inc >= eff_l;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid &&
                        (!out_valid_r || out_ch.ready);
  assign cfg_ch.ready = (state_r == S_IDLE);

  idef_ram #(.WIDTH(8), .DEPTH(MAX_LINE_BYTES)) u_ram_upper (
    .clk   (clk),
    .we    (state_r == S_CALC),
    .waddr (col_r),
    .wdata (lo),
    .raddr (col_r),
    .rdata (up)
  );

  idef_ram #(.WIDTH(8), .DEPTH(MAX_LINE_BYTES)) u_ram_lower (
    .clk   (clk),
    .we    (state_r == S_CALC),
    .waddr (col_r),
    .wdata (pix_r),
    .raddr (col_r),
    .rdata (lo)
  );

  assign dy       = absdiff(pix_r, lo);
  assign dx       = absdiff(pix_r, colour_r ? win_r[2][2] : win_r[2][0]);
  assign in_last  = (row_r == eff_r - RW'(1)) && (LW'(col_r) == eff_l - LW'(1));
  assign out_last = (orow_r == eff_r - RW'(1)) && (LW'(ocol_r) == eff_l - LW'(1));
  assign vert_ok  = row_r != '0;
  assign horiz_ok = LW'(col_r) >= stride;
  assign emit3    = (ipos_r >= PW'(lag)) && (opos_r + PW'(lag) == ipos_r);
  assign kern_ok  = (orow_r != '0) && (orow_r + RW'(1) < eff_r) &&
                    (LW'(ocol_r) >= stride) && (LW'(ocol_r) + stride < eff_l);

  assign t0 = colour_r ? win_r[0][5] : win_r[0][1];
  assign t1 = colour_r ? win_r[0][2] : win_r[0][0];
  assign m0 = colour_r ? win_r[1][5] : win_r[1][1];
  assign m1 = colour_r ? win_r[1][2] : win_r[1][0];
  assign b0 = colour_r ? win_r[2][5] : win_r[2][1];
  assign b1 = colour_r ? win_r[2][2] : win_r[2][0];

  always_comb begin
    if (mode_r == MODE_CROSS) begin
      ksum = 12'(t0) + 12'(up) + 12'(b0) + 12'(pix_r) + (12'(m1) << 2)
           - ((12'(t1) + 12'(m0) + 12'(lo) + 12'(b1)) << 1);
    end else begin
      ksum = 12'(t0) + 12'(t1) + 12'(up) + 12'(m0) + 12'(lo) + 12'(b0)
           + 12'(b1) + 12'(pix_r) - (12'(m1) << 3);
    end
    kmag = ksum[11] ? 12'(-ksum) : 12'(ksum);
    kres = (kmag > 12'd255) ? SAT_MAX : kmag[7:0];
  end

  assign sq_val   = 17'(dx) * 17'(dx) + 17'(dy) * 17'(dy);
  assign sq_start = (state_r == S_CALC) && (mode_r == MODE_MAG) && vert_ok && horiz_ok;

  idef_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .val   (sq_val),
    .done  (sq_done),
    .root  (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_VERT;
      colour_r    <= 1'b0;
      lb_r        <= CFG_W'(640);
      rows_r      <= CFG_W'(480);
      col_r       <= '0;
      row_r       <= '0;
      ipos_r      <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      opos_r      <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 7; k++) begin
          win_r[r][k] <= '0;
        end
      end
    end else begin
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cfg_acc && (cfg_ch.data.index <= REG_ROWS)) begin
            unique case (cfg_ch.data.index)
              REG_MODE:       mode_r   <= cfg_ch.data.value[2:0];
              REG_COLOUR:     colour_r <= cfg_ch.data.value[0];
              REG_LINE_BYTES: lb_r     <= cfg_ch.data.value;
              REG_ROWS:       rows_r   <= cfg_ch.data.value;
              default: ;
            endcase
            col_r  <= '0;
            row_r  <= '0;
            ipos_r <= '0;
            ocol_r <= '0;
            orow_r <= '0;
            opos_r <= '0;
            for (int r = 0; r < 3; r++) begin
              for (int k = 0; k < 7; k++) begin
                win_r[r][k] <= '0;
              end
            end
          end else if (in_acc && (in_ch.data.action == ACT_DRAIN)) begin
            if (opos_r < ipos_r) begin
              out_valid_r         <= 1'b1;
              out_data_r.edge_res <= SAT_MAX;
              out_data_r.last     <= out_last;
              if (out_last) begin
                col_r  <= '0;
                row_r  <= '0;
                ipos_r <= '0;
                ocol_r <= '0;
                orow_r <= '0;
                opos_r <= '0;
                for (int r = 0; r < 3; r++) begin
                  for (int k = 0; k < 7; k++) begin
                    win_r[r][k] <= '0;
                  end
                end
              end else begin
                opos_r <= opos_r + PW'(1);
                ocol_r <= ocol_wrap ? '0 : AW'(ocol_inc);
                orow_r <= orow_r + RW'(ocol_wrap);
              end
            end
          end else if (in_acc) begin
            pix_r   <= in_ch.data.pixel;
            state_r <= S_CALC;
            if (row_r >= eff_r) begin
              col_r  <= '0;
              row_r  <= '0;
              ipos_r <= '0;
              ocol_r <= '0;
              orow_r <= '0;
              opos_r <= '0;
              for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 7; k++) begin
                  win_r[r][k] <= '0;
                end
              end
            end
          end
        end
        S_CALC: begin
          state_r <= S_IDLE;
          for (int r = 0; r < 3; r++) begin
            for (int k = 6; k > 0; k--) begin
              win_r[r][k] <= win_r[r][k-1];
            end
          end
          win_r[0][0] <= up;
          win_r[1][0] <= lo;
          win_r[2][0] <= pix_r;
          col_r  <= col_wrap ? '0 : AW'(col_inc);
          row_r  <= row_r + RW'(col_wrap);
          ipos_r <= ipos_r + PW'(1);
          if (mode_r < MODE_CROSS) begin
            if (mode_r == MODE_VERT) begin
              out_valid_r         <= 1'b1;
              out_data_r.edge_res <= vert_ok ? dy : SAT_MAX;
            end else if (mode_r == MODE_HORIZ) begin
              out_valid_r         <= 1'b1;
              out_data_r.edge_res <= horiz_ok ? dx : SAT_MAX;
            end else if (sq_start) begin
              state_r <= S_SQRT;
            end else begin
              out_valid_r         <= 1'b1;
              out_data_r.edge_res <= SAT_MAX;
            end
            out_data_r.last <= in_last;
            mag_last_r      <= in_last;
            opos_r <= ipos_r + PW'(1);
            ocol_r <= col_wrap ? '0 : AW'(col_inc);
            orow_r <= row_r + RW'(col_wrap);
            if (in_last) begin
              col_r  <= '0;
              row_r  <= '0;
              ipos_r <= '0;
              ocol_r <= '0;
              orow_r <= '0;
              opos_r <= '0;
              for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 7; k++) begin
                  win_r[r][k] <= '0;
                end
              end
            end
          end else if (emit3) begin
            out_valid_r         <= 1'b1;
            out_data_r.edge_res <= kern_ok ? kres : SAT_MAX;
            out_data_r.last     <= out_last;
            opos_r <= opos_r + PW'(1);
            ocol_r <= ocol_wrap ? '0 : AW'(ocol_inc);
            orow_r <= orow_r + RW'(ocol_wrap);
            if (out_last) begin
              col_r  <= '0;
              row_r  <= '0;
              ipos_r <= '0;
              ocol_r <= '0;
              orow_r <= '0;
              opos_r <= '0;
              for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 7; k++) begin
                  win_r[r][k] <= '0;
                end
              end
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            out_valid_r         <= 1'b1;
            out_data_r.edge_res <= sq_root;
            out_data_r.last     <= mag_last_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("input ready while an item is in work");

  a_pixel_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && in_acc && (in_ch.data.action == ACT_PIXEL) && !cfg_acc) |=> (state_r == S_CALC))
    else $error("pixel beat did not start the line store pass");

  a_root_in_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == S_SQRT))
    else $error("root finished outside the root state");

  a_out_free_in_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> !out_valid_r)
    else $error("output register busy while root runs");

endmodule

// ----- sim/idef_edge_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idef_edge_checker
// Scoreboard for the edge filter. It watches the input, result and register
// channels and predicts each result byte from a local model of the line
// stores, the window and the frame counters. Each result beat is checked
// against the oldest prediction, and mismatches are counted for the top.
// ----------------------------------------------------------------------------
module idef_edge_checker import idef_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  idef_chan_if in_mon,
  idef_chan_if out_mon,
  idef_chan_if cfg_mon,
  output int   fail_cnt,
  output int   pending,
  output int   result_cnt
);

  localparam int LINE_MAX = 4096;
  localparam int ROW_MAX  = 4096;

  logic [7:0]  upper_line [LINE_MAX];
  logic [7:0]  lower_line [LINE_MAX];
  logic [7:0]  win [3][7];
  int unsigned col, row, out_pos;
  logic [2:0]  mode_r;
  logic        colour_r;
  logic [12:0] lbytes_r, rows_r;
  out_beat_t   edge_q[$];

  function automatic void restart_frame();
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 7; k++) win[r][k] = 8'd0;
    col = 0;
    row = 0;
    out_pos = 0;
  endfunction

  function automatic int unsigned isqrt_sat(input int unsigned v);
    int unsigned r;
    r = 0;
    if (v >= 65536) return 255;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic int unsigned diff_mag(input int unsigned a, input int unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic predict_beat(input in_beat_t b);
    int unsigned nl, nr, s, lag, fr, x, y, pos, up, lo, dx, dy, oy, ox, res, n;
    int          sum, t0, t1, t2, m0, m1, m2, b0, b1, b2;
    out_beat_t   e;
    nl  = (lbytes_r == 0) ? 1 : ((lbytes_r > LINE_MAX) ? LINE_MAX : lbytes_r);
    nr  = (rows_r == 0) ? 1 : ((rows_r > ROW_MAX) ? ROW_MAX : rows_r);
    s   = colour_r ? 3 : 1;
    lag = nl + s;
    fr  = nr * nl;
    if (b.action == ACT_DRAIN) begin
      n = row * nl + col;
      if (out_pos >= n) return;
      e.edge_res = SAT_MAX;
      e.last     = (out_pos == fr - 1);
      edge_q.push_back(e);
      if (out_pos == fr - 1) restart_frame();
      else out_pos++;
      return;
    end
    if (row >= nr) restart_frame();
    x = (col >= LINE_MAX) ? LINE_MAX - 1 : col;
    y = row;
    up = upper_line[x];
    lo = lower_line[x];
    upper_line[x] = lo[7:0];
    lower_line[x] = b.pixel;
    for (int r = 0; r < 3; r++)
      for (int k = 6; k > 0; k--) win[r][k] = win[r][k-1];
    win[0][0] = up[7:0];
    win[1][0] = lo[7:0];
    win[2][0] = b.pixel;
    pos = y * nl + x;
    col++;
    if (col >= nl) begin
      col = 0;
      row++;
    end
    if (mode_r < MODE_CROSS) begin
      dy = diff_mag(b.pixel, lo);
      dx = diff_mag(b.pixel, win[2][s]);
      if (mode_r == MODE_VERT) res = (y >= 1) ? dy : 255;
      else if (mode_r == MODE_HORIZ) res = (x >= s) ? dx : 255;
      else res = (y >= 1 && x >= s) ? isqrt_sat(dx * dx + dy * dy) : 255;
      e.edge_res = res[7:0];
      e.last     = (pos == fr - 1);
      edge_q.push_back(e);
      if (pos == fr - 1) restart_frame();
      else out_pos = pos + 1;
      return;
    end
    if (pos < lag || out_pos != pos - lag) return;
    oy = out_pos / nl;
    ox = out_pos % nl;
    if (oy >= 1 && oy + 1 < nr && ox >= s && ox + s < nl) begin
      t0 = win[0][2*s]; t1 = win[0][s]; t2 = win[0][0];
      m0 = win[1][2*s]; m1 = win[1][s]; m2 = win[1][0];
      b0 = win[2][2*s]; b1 = win[2][s]; b2 = win[2][0];
      if (mode_r == MODE_CROSS)
        sum = t0 - 2*t1 + t2 - 2*m0 + 4*m1 - 2*m2 + b0 - 2*b1 + b2;
      else
        sum = t0 + t1 + t2 + m0 - 8*m1 + m2 + b0 + b1 + b2;
      if (sum < 0) sum = -sum;
      res = (sum > 255) ? 255 : sum;
    end else begin
      res = 255;
    end
    e.edge_res = res[7:0];
    e.last     = (out_pos == fr - 1);
    edge_q.push_back(e);
    if (out_pos == fr - 1) restart_frame();
    else out_pos++;
  endtask

  initial begin
    for (int i = 0; i < LINE_MAX; i++) begin
      upper_line[i] = 8'd0;
      lower_line[i] = 8'd0;
    end
    fail_cnt   = 0;
    pending    = 0;
    result_cnt = 0;
  end

  always @(posedge clk) begin
    cfg_beat_t c;
    out_beat_t got, want;
    if (!rst_n) begin
      mode_r   = MODE_VERT;
      colour_r = 1'b0;
      lbytes_r = 13'd640;
      rows_r   = 13'd480;
      restart_frame();
      edge_q.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        c = cfg_mon.data;
        case (c.index)
          REG_MODE: begin
            mode_r = c.value[2:0];
            restart_frame();
          end
          REG_COLOUR: begin
            colour_r = c.value[0];
            restart_frame();
          end
          REG_LINE_BYTES: begin
            lbytes_r = c.value;
            restart_frame();
          end
          REG_ROWS: begin
            rows_r = c.value;
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_beat(in_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        result_cnt++;
        if (edge_q.size() == 0) begin
          $error("unexpected result beat: edge_res=%0d last=%0b", got.edge_res, got.last);
          fail_cnt++;
        end else begin
          want = edge_q.pop_front();
          if (got.edge_res !== want.edge_res) begin
            $error("edge_res mismatch: expected %0d, got %0d", want.edge_res, got.edge_res);
            fail_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, got.last);
            fail_cnt++;
          end
        end
      end
    end
    pending = edge_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the edge filter. Directed frames hit pixel
// extremes and the drain path, then random phases sweep every mode, both
// strides and clamped sizes with whole frames, broken frames and stray
// drains, under bursty input and a stalling result side.
// ----------------------------------------------------------------------------
module tb_top;
  import idef_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_500_000;
  localparam int          RANDOM_ITEMS = 700;
  localparam logic [2:0]  MODE_EIGHT   = 3'd4;
  localparam logic [2:0]  MODE_TOP     = 3'd7;

  logic clk;
  logic rst_n;
  int   fail_cnt, pending, result_cnt;
  int   beats_sent, phases, cycles;
  int   burst_left;
  int   hold_ask, hold_done;
  int   cur_lines, cur_stride;
  logic [2:0] cur_mode;

  idef_chan_if #(.T(in_beat_t))  in_ch ();
  idef_chan_if #(.T(out_beat_t)) out_ch ();
  idef_chan_if #(.T(cfg_beat_t)) cfg_ch ();

  image_derivative_edge_filter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  idef_edge_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_cnt   (fail_cnt),
    .pending    (pending),
    .result_cnt (result_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** image_derivative_edge_filter: FAILED **");
      $finish;
    end
  end

  // result side: changing stall style, plus long hold-offs on request
  initial begin
    int hold_left, style, style_left;
    hold_left  = 0;
    style      = 0;
    style_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left == 0 && hold_done != hold_ask) begin
        hold_done = hold_ask;
        hold_left = $urandom_range(200, 400);
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(16, 128);
      end
      style_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      @(posedge clk);
    end
  end

  task automatic send_beat(input logic act, input logic [7:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{action: act, pixel: pix};
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    wait (pending == 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic configure(input logic [2:0] m, input logic c,
                           input logic [12:0] lb, input logic [12:0] nr);
    go_idle();
    write_reg(REG_MODE, CFG_W'(m));
    write_reg(REG_COLOUR, CFG_W'(c));
    write_reg(REG_LINE_BYTES, lb);
    write_reg(REG_ROWS, nr);
    cur_mode   = m;
    cur_stride = c ? 3 : 1;
    cur_lines  = (lb == 0) ? 1 : ((lb > 4096) ? 4096 : lb);
    phases++;
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_frame(input int nbytes, input bit noisy);
    int lag, ndrain;
    lag = cur_lines + cur_stride;
    for (int i = 0; i < nbytes; i++) begin
      if (noisy && $urandom_range(0, 24) == 0)
        send_beat(ACT_DRAIN, 8'($urandom_range(0, 255)));
      if (noisy && $urandom_range(0, 299) == 0) go_idle();
      send_beat(ACT_PIXEL, pick_pixel());
    end
    if (cur_mode >= MODE_CROSS)
      ndrain = ($urandom_range(0, 4) != 0) ? lag + $urandom_range(0, 1)
                                           : $urandom_range(0, lag + 2);
    else
      ndrain = ($urandom_range(0, 9) == 0) ? 1 : 0;
    if (ndrain > nbytes + 2) ndrain = nbytes + 2;
    repeat (ndrain) send_beat(ACT_DRAIN, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [12:0] lb, nr;
    int eff_rows, nbytes, base;
    rst_n        = 1'b0;
    cycles       = 0;
    beats_sent   = 0;
    phases       = 0;
    burst_left   = 0;
    hold_ask     = 0;
    hold_done    = 0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pixel extremes on a 3x3 grey frame, then the Laplacian with drains
    configure(MODE_VERT, 1'b0, 13'd3, 13'd3);
    send_beat(ACT_PIXEL, 8'd0);   send_beat(ACT_PIXEL, 8'd255); send_beat(ACT_PIXEL, 8'd0);
    send_beat(ACT_PIXEL, 8'd255); send_beat(ACT_PIXEL, 8'd128); send_beat(ACT_PIXEL, 8'd255);
    send_beat(ACT_PIXEL, 8'd0);   send_beat(ACT_PIXEL, 8'd0);   send_beat(ACT_PIXEL, 8'd255);
    configure(MODE_EIGHT, 1'b0, 13'd3, 13'd3);
    for (int i = 0; i < 9; i++) send_beat(ACT_PIXEL, (i == 4) ? 8'd0 : 8'd255);
    repeat (5) send_beat(ACT_DRAIN, 8'd255);

    base = beats_sent;
    while (beats_sent - base < RANDOM_ITEMS) begin
      lb = ($urandom_range(0, 14) == 0) ? 13'd0 :
           ($urandom_range(0, 14) == 0) ? 13'($urandom_range(13, 24))
                                        : 13'($urandom_range(1, 12));
      nr = ($urandom_range(0, 14) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
      configure(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), lb, nr);
      if (phases == 3 || $urandom_range(0, 5) == 0) hold_ask++;
      eff_rows = (nr == 0) ? 1 : nr;
      repeat ($urandom_range(1, 3)) begin
        nbytes = cur_lines * eff_rows;
        if ($urandom_range(0, 7) == 0) nbytes = $urandom_range(0, nbytes);
        run_frame(nbytes, 1'b1);
      end
    end

    // widest line with the stride of three, then clamped sizes
    configure(MODE_CROSS, 1'b1, 13'd4096, 13'd1);
    run_frame(256, 1'b0);
    configure(MODE_TOP, 1'b0, 13'h1FFF, 13'h1FFF);
    run_frame(150, 1'b1);
    configure(MODE_MAG, 1'b1, 13'd5, 13'h1FFF);
    run_frame(200, 1'b1);

    go_idle();
    $display("run: %0d input beats over %0d register settings, %0d result beats checked",
             beats_sent, phases, result_cnt);
    $display("modes 0-7, both strides, clamped sizes, drains and back-pressure exercised");
    if (fail_cnt == 0) begin
      $display("** image_derivative_edge_filter: PASSED **");
    end else begin
      $display("** image_derivative_edge_filter: FAILED **");
    end
    $finish;
  end

endmodule

// ----- image_derivative_edge_filter.f -----
src/idef_pkg.sv
src/idef_chan_if.sv
src/idef_ram.sv
src/idef_sqrt.sv
src/image_derivative_edge_filter.sv
sim/idef_edge_checker.sv
sim/tb_top.sv
